// File: src/eida_pkg.sv
// Shared types and constants for the entity ID allocator table.
`timescale 1ns / 1ps

package eida_pkg;

  localparam int unsigned MaxEntities = 256;
  localparam int unsigned SigBits     = 32;
  localparam int unsigned SlotBits    = 8;
  localparam int unsigned IdBits      = $clog2(MaxEntities);
  localparam int unsigned CountBits   = IdBits + 1;
  localparam int unsigned EntryBits   = SigBits + SlotBits;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_ASSIGN = 2'd2,
    OP_QUERY  = 2'd3
  } eida_op_e;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_FULL  = 3'd1,
    STAT_NEVER = 3'd2,
    STAT_DEAD  = 3'd3,
    STAT_NOSIG = 3'd4
  } eida_status_e;

  typedef struct packed {
    eida_op_e              opcode;
    logic [IdBits-1:0]     entity_id;
    logic [SigBits-1:0]    signature_in;
    logic [SlotBits-1:0]   slot_index_in;
  } eida_in_t;

  typedef struct packed {
    eida_status_e          status;
    logic [IdBits-1:0]     new_entity;
    logic                  alive;
    logic [SigBits-1:0]    signature_out;
    logic [SlotBits-1:0]   slot_index_out;
  } eida_out_t;

  typedef struct packed {
    logic [SigBits-1:0]    sig;
    logic [SlotBits-1:0]   slot;
  } eida_entry_t;

endpackage

// File: src/entity_id_allocator_table.sv
// Top level of the entity ID allocator with its per-entity signature and slot table.
// Create, assign, query and refused operations pass the read, eval and done states.
// A remove of an entity with a signature walks the entry RAM, one entry per cycle over all
// issued IDs, decrementing each higher slot index held under the removed signature.
// One item is in work at a time; the next transfer is taken once the result is registered.
// Reset clears the control state and the dead and signature-valid bits; the RAMs are not cleared.
`timescale 1ns / 1ps

module entity_id_allocator_table
  import eida_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  eida_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output eida_out_t out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_WALK,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  eida_in_t               req_q, req_d;
  eida_out_t              res_q, res_d;
  eida_out_t              out_data_q, out_data_d;
  logic                   out_valid_q, out_valid_d;
  logic [CountBits-1:0]   fresh_count_q, fresh_count_d;
  logic [IdBits-1:0]      free_head_q, free_head_d;
  logic [IdBits-1:0]      free_tail_q, free_tail_d;
  logic [CountBits-1:0]   free_count_q, free_count_d;
  logic [MaxEntities-1:0] dead_q, dead_d;
  logic [MaxEntities-1:0] sigv_q, sigv_d;
  logic [SigBits-1:0]     rs_q, rs_d;
  logic [SlotBits-1:0]    rslot_q, rslot_d;
  logic [CountBits-1:0]   cnt_q, cnt_d;
  logic                   wv_q, wv_d;
  logic [IdBits-1:0]      wa_q, wa_d;

  logic                   fifo_we;
  logic [IdBits-1:0]      fifo_waddr;
  logic [IdBits-1:0]      fifo_wdata;
  logic [IdBits-1:0]      fifo_raddr;
  logic [IdBits-1:0]      fifo_rdata;
  logic                   ent_we;
  logic [IdBits-1:0]      ent_waddr;
  eida_entry_t            ent_wdata;
  logic [IdBits-1:0]      ent_raddr;
  eida_entry_t            ent_rdata;

  function automatic logic [IdBits-1:0] wrap_next(input logic [IdBits-1:0] p);
    return (p == IdBits'(MaxEntities - 1)) ? '0 : p + 1'b1;
  endfunction

  eida_ram #(
    .Width (IdBits),
    .Depth (MaxEntities)
  ) u_free_fifo (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  eida_ram #(
    .Width (EntryBits),
    .Depth (MaxEntities)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    res_d         = res_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_data_d    = out_data_q;
    fresh_count_d = fresh_count_q;
    free_head_d   = free_head_q;
    free_tail_d   = free_tail_q;
    free_count_d  = free_count_q;
    dead_d        = dead_q;
    sigv_d        = sigv_q;
    rs_d          = rs_q;
    rslot_d       = rslot_q;
    cnt_d         = cnt_q;
    wv_d          = 1'b0;
    wa_d          = wa_q;
    fifo_we       = 1'b0;
    fifo_waddr    = free_tail_q;
    fifo_wdata    = req_q.entity_id;
    fifo_raddr    = free_head_q;
    ent_we        = 1'b0;
    ent_waddr     = req_q.entity_id;
    ent_wdata     = '{sig: req_q.signature_in, slot: req_q.slot_index_in};
    ent_raddr     = req_q.entity_id;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        res_d   = '0;
        state_d = S_DONE;
        if (req_q.opcode == OP_CREATE) begin
          if (free_count_q != '0) begin
            res_d.new_entity   = fifo_rdata;
            free_head_d        = wrap_next(free_head_q);
            free_count_d       = free_count_q - 1'b1;
            dead_d[fifo_rdata] = 1'b0;
            sigv_d[fifo_rdata] = 1'b0;
          end else if (fresh_count_q < CountBits'(MaxEntities)) begin
            res_d.new_entity = fresh_count_q[IdBits-1:0];
            fresh_count_d    = fresh_count_q + 1'b1;
          end else begin
            res_d.status = STAT_FULL;
          end
        end else if ({1'b0, req_q.entity_id} >= fresh_count_q) begin
          res_d.status = STAT_NEVER;
        end else if (dead_q[req_q.entity_id]) begin
          res_d.status = STAT_DEAD;
        end else if (req_q.opcode == OP_REMOVE) begin
          dead_d[req_q.entity_id] = 1'b1;
          if (free_count_q < CountBits'(MaxEntities)) begin
            fifo_we      = 1'b1;
            free_tail_d  = wrap_next(free_tail_q);
            free_count_d = free_count_q + 1'b1;
          end
          if (sigv_q[req_q.entity_id]) begin
            sigv_d[req_q.entity_id] = 1'b0;
            rs_d    = ent_rdata.sig;
            rslot_d = ent_rdata.slot;
            cnt_d   = '0;
            state_d = S_WALK;
          end
        end else if (req_q.opcode == OP_ASSIGN) begin
          sigv_d[req_q.entity_id] = 1'b1;
          ent_we = 1'b1;
        end else begin
          res_d.alive = 1'b1;
          if (sigv_q[req_q.entity_id]) begin
            res_d.signature_out  = ent_rdata.sig;
            res_d.slot_index_out = ent_rdata.slot;
          end else begin
            res_d.status = STAT_NOSIG;
          end
        end
      end
      S_WALK: begin
        if (cnt_q < fresh_count_q) begin
          ent_raddr = cnt_q[IdBits-1:0];
          cnt_d     = cnt_q + 1'b1;
          wv_d      = 1'b1;
          wa_d      = cnt_q[IdBits-1:0];
        end
        if (wv_q && sigv_q[wa_q] && (ent_rdata.sig == rs_q) && (ent_rdata.slot > rslot_q)) begin
          ent_we    = 1'b1;
          ent_waddr = wa_q;
          ent_wdata = '{sig: ent_rdata.sig, slot: ent_rdata.slot - 1'b1};
        end
        if ((cnt_q >= fresh_count_q) && !wv_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      req_q         <= '0;
      res_q         <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      fresh_count_q <= '0;
      free_head_q   <= '0;
      free_tail_q   <= '0;
      free_count_q  <= '0;
      dead_q        <= '0;
      sigv_q        <= '0;
      rs_q          <= '0;
      rslot_q       <= '0;
      cnt_q         <= '0;
      wv_q          <= 1'b0;
      wa_q          <= '0;
    end else begin
      state_q       <= state_d;
      req_q         <= req_d;
      res_q         <= res_d;
      out_valid_q   <= out_valid_d;
      out_data_q    <= out_data_d;
      fresh_count_q <= fresh_count_d;
      free_head_q   <= free_head_d;
      free_tail_q   <= free_tail_d;
      free_count_q  <= free_count_d;
      dead_q        <= dead_d;
      sigv_q        <= sigv_d;
      rs_q          <= rs_d;
      rslot_q       <= rslot_d;
      cnt_q         <= cnt_d;
      wv_q          <= wv_d;
      wa_q          <= wa_d;
    end
  end

endmodule

// File: src/eida_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module eida_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/eida_checker.sv
// Port-level checker for the entity ID allocator table, bound to the top level.
`timescale 1ns / 1ps

module eida_checker
  import eida_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input eida_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input eida_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result changed or dropped while stalled.");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input ready stayed high after a transfer.");

  a_full_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_FULL) |-> (out_data_o.new_entity == '0))
    else $error("Full create handed out an ID.");

  a_alive_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.alive |->
      (out_data_o.status == STAT_OK) || (out_data_o.status == STAT_NOSIG))
    else $error("Alive reported with an error status.");

  a_err_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STAT_OK) |->
      (out_data_o.signature_out == '0) && (out_data_o.slot_index_out == '0))
    else $error("Signature or slot index reported with a non-ok status.");

endmodule

bind entity_id_allocator_table eida_checker u_eida_checker (.*);
